[rtl/quaternion_to_euler_angles_defines.svh]
// Assertion macros used by the checker of the quaternion to Euler converter.
`ifndef QUATERNION_TO_EULER_ANGLES_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QTE_ASSERT_IMPL(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("qte: property violated");

// Next-cycle implication, disabled while reset is asserted.
`define QTE_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("qte: property violated");

`endif

[rtl/qte_pkg.sv]
// Shared constants, CORDIC angle table and width helpers of the quaternion to Euler converter.
package qte_pkg;

  localparam int CB_DEFAULT   = 16;
  localparam int AB_DEFAULT   = 16;
  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_DIGITS  = 31;
  localparam int QUEUE_DEPTH  = 2;

  // 32-bit binary angles, 2^32 is a full turn
  localparam logic [31:0] ANG_PI          = 32'h8000_0000;
  localparam logic [31:0] ANG_HALF_PI     = 32'h4000_0000;
  localparam logic [31:0] ANG_NEG_HALF_PI = 32'hC000_0000;

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1
  };

  // right shift applied to component products to keep the working frame narrow
  function automatic int prod_shift(int cb);
    int f2;
    f2 = 2 * (cb - 1);
    return (f2 > 46) ? (f2 - 46) : 0;
  endfunction

  // fraction bits of the working frame
  function automatic int work_frac(int cb);
    return 2 * (cb - 1) - prod_shift(cb);
  endfunction

  // datapath width of the CORDIC vectors, covers gain and sign
  function automatic int cordic_width(int cb);
    int wf;
    wf = work_frac(cb);
    return ((wf > 30) ? wf : 30) + 5;
  endfunction

endpackage

[rtl/qte_if.sv]
// Valid/ready channel interfaces for quaternion requests and Euler angle results.
interface qte_in_if import qte_pkg::*; #(
  parameter int COMPONENT_BITS = CB_DEFAULT
);
  logic                             valid;
  logic                             ready;
  logic signed [COMPONENT_BITS-1:0] q_w;
  logic signed [COMPONENT_BITS-1:0] q_x;
  logic signed [COMPONENT_BITS-1:0] q_y;
  logic signed [COMPONENT_BITS-1:0] q_z;

  modport source (output valid, q_w, q_x, q_y, q_z, input ready);
  modport sink   (input valid, q_w, q_x, q_y, q_z, output ready);
endinterface

interface qte_out_if import qte_pkg::*; #(
  parameter int ANGLE_BITS = AB_DEFAULT
);
  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] roll;
  logic signed [ANGLE_BITS-1:0] pitch;
  logic signed [ANGLE_BITS-1:0] yaw;
  logic                         pitch_clamped;

  modport source (output valid, roll, pitch, yaw, pitch_clamped, input ready);
  modport sink   (input valid, roll, pitch, yaw, pitch_clamped, output ready);
endinterface

[rtl/qte_front.sv]
// Front end: accept a quaternion, form products, atan2 operands and the clamped asin argument.
module qte_front import qte_pkg::*; #(
  parameter int COMPONENT_BITS = CB_DEFAULT,
  parameter int CW             = cordic_width(CB_DEFAULT),
  parameter int QW             = 4 * cordic_width(CB_DEFAULT) + 33
) (
  input  logic          clk,
  input  logic          rst_n,
  qte_in_if.sink        in_ch,
  output logic          push,
  output logic [QW-1:0] push_data,
  input  logic          q_full
);

  localparam int CB = COMPONENT_BITS;
  localparam int PS = prod_shift(COMPONENT_BITS);
  localparam int WF = work_frac(COMPONENT_BITS);
  localparam int PW = 2 * COMPONENT_BITS - PS;
  localparam logic signed [CW-1:0] ONE_W  = CW'(64'd1 << WF);
  localparam logic signed [CW-1:0] HALF_W = CW'(64'd1 << (WF - 1));

  logic advance;
  logic s1_vld_r, s2_vld_r;

  logic signed [PW-1:0] p_xx_r, p_yy_r, p_zz_r, p_yz_r, p_wx_r;
  logic signed [PW-1:0] p_xy_r, p_wz_r, p_wy_r, p_xz_r;

  logic signed [CW-1:0] rn_nxt, rd_nxt, yn_nxt, yd_nxt, s_c, sc_c;
  logic                 clamp_nxt;
  logic signed [31:0]   t_c;

  logic signed [CW-1:0] rn_r, rd_r, yn_r, yd_r;
  logic signed [31:0]   t_r;
  logic                 clamp_r;

  // floor-shifted product in the working frame
  function automatic logic signed [PW-1:0] mulp(logic signed [CB-1:0] a,
                                                logic signed [CB-1:0] b);
    logic signed [2*CB-1:0] ae, be, full, sh;
    ae   = a;
    be   = b;
    full = ae * be;
    sh   = full >>> PS;
    return sh[PW-1:0];
  endfunction

  // hold both stages while the second one cannot hand its request on
  assign advance     = !s2_vld_r || !q_full;
  assign in_ch.ready = advance;
  assign push        = s2_vld_r && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (advance) begin
      s1_vld_r <= in_ch.valid;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p_xx_r <= mulp(in_ch.q_x, in_ch.q_x);
      p_yy_r <= mulp(in_ch.q_y, in_ch.q_y);
      p_zz_r <= mulp(in_ch.q_z, in_ch.q_z);
      p_yz_r <= mulp(in_ch.q_y, in_ch.q_z);
      p_wx_r <= mulp(in_ch.q_w, in_ch.q_x);
      p_xy_r <= mulp(in_ch.q_x, in_ch.q_y);
      p_wz_r <= mulp(in_ch.q_w, in_ch.q_z);
      p_wy_r <= mulp(in_ch.q_w, in_ch.q_y);
      p_xz_r <= mulp(in_ch.q_x, in_ch.q_z);
    end
  end

  always_comb begin
    rn_nxt    = CW'(p_yz_r) + CW'(p_wx_r);
    rd_nxt    = HALF_W - (CW'(p_xx_r) + CW'(p_yy_r));
    yn_nxt    = CW'(p_xy_r) + CW'(p_wz_r);
    yd_nxt    = HALF_W - (CW'(p_yy_r) + CW'(p_zz_r));
    s_c       = (CW'(p_wy_r) - CW'(p_xz_r)) <<< 1;
    sc_c      = s_c;
    clamp_nxt = 1'b0;
    if (s_c > ONE_W) begin
      sc_c      = ONE_W;
      clamp_nxt = 1'b1;
    end else if (s_c < -ONE_W) begin
      sc_c      = -ONE_W;
      clamp_nxt = 1'b1;
    end
  end

  // bring the asin argument to 30 fraction bits
  generate
    if (WF >= 30) begin : g_t_down
      assign t_c = 32'(sc_c >>> (WF - 30));
    end else begin : g_t_up
      assign t_c = 32'(sc_c <<< (30 - WF));
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (advance) begin
      rn_r    <= rn_nxt;
      rd_r    <= rd_nxt;
      yn_r    <= yn_nxt;
      yd_r    <= yd_nxt;
      t_r     <= t_c;
      clamp_r <= clamp_nxt;
    end
  end

  assign push_data = {rn_r, rd_r, yn_r, yd_r, t_r, clamp_r};

endmodule

[rtl/qte_queue.sv]
// Small register queue that decouples the front end from the back end.
module qte_queue import qte_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam logic [PTRW-1:0] LAST = PTRW'(DEPTH - 1);

  logic [W-1:0]    mem_r [DEPTH];
  logic [PTRW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] cnt_r;

  assign full  = (cnt_r == CNTW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

[rtl/qte_cordic.sv]
// Pipelined vectoring CORDIC: atan2 of one operand pair as a 32-bit binary angle.
module qte_cordic import qte_pkg::*; #(
  parameter int CW = cordic_width(CB_DEFAULT)
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] y_i,
  input  logic signed [CW-1:0] x_i,
  output logic [31:0]          z_o
);

  localparam int N = CORDIC_STEPS;

  logic signed [CW-1:0] x_r [0:N];
  logic signed [CW-1:0] y_r [0:N];
  logic [31:0]          z_r [0:N];
  logic [31:0]          ang_r [0:N];
  logic                 byp_r [0:N];

  logic signed [CW-1:0] xp, yp;
  logic [31:0]          zp, ang_c;
  logic                 byp_c;

  // axis cases bypass the iterations; left half plane is folded over by pi
  always_comb begin
    xp    = x_i;
    yp    = y_i;
    zp    = '0;
    byp_c = 1'b0;
    ang_c = '0;
    if (y_i == '0) begin
      byp_c = 1'b1;
      ang_c = x_i[CW-1] ? ANG_PI : '0;
    end else if (x_i == '0) begin
      byp_c = 1'b1;
      ang_c = y_i[CW-1] ? ANG_NEG_HALF_PI : ANG_HALF_PI;
    end else if (x_i[CW-1]) begin
      xp = -x_i;
      yp = -y_i;
      zp = ANG_PI;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]   <= xp;
      y_r[0]   <= yp;
      z_r[0]   <= zp;
      byp_r[0] <= byp_c;
      ang_r[0] <= ang_c;
      for (int i = 0; i < N; i++) begin
        if (y_r[i][CW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ATAN_TAB[i];
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ATAN_TAB[i];
        end
        byp_r[i+1] <= byp_r[i];
        ang_r[i+1] <= ang_r[i];
      end
    end
  end

  assign z_o = byp_r[N] ? ang_r[N] : z_r[N];

endmodule

[rtl/qte_back.sv]
// Back end: square root, three CORDICs, pitch limit, rounding and the result register.
module qte_back import qte_pkg::*; #(
  parameter int ANGLE_BITS = AB_DEFAULT,
  parameter int CW         = cordic_width(CB_DEFAULT),
  parameter int QW         = 4 * cordic_width(CB_DEFAULT) + 33
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  logic [QW-1:0] q_dout,
  output logic          q_pop,
  qte_out_if.source     out_ch
);

  localparam int AB  = ANGLE_BITS;
  localparam int SQ  = SQRT_DIGITS;
  localparam int CL  = CORDIC_STEPS + 1;
  localparam int END = SQ + CL;
  localparam logic [32:0] RND_HALF = (33'd1 << (32 - AB)) >> 1;
  localparam logic signed [31:0] LIM_POS = ANG_HALF_PI;
  localparam logic signed [31:0] LIM_NEG = ANG_NEG_HALF_PI;

  logic advance;
  logic vld_r [0:END];

  logic signed [CW-1:0] rn_q, rd_q, yn_q, yd_q;
  logic signed [31:0]   t_q;
  logic                 clamp_q;
  logic [30:0]          t_abs;

  logic signed [CW-1:0] rn_r, rd_r, yn_r, yd_r;
  logic [61:0]          n_r    [0:SQ];
  logic [32:0]          rem_r  [0:SQ];
  logic [30:0]          root_r [0:SQ];
  logic signed [31:0]   t_d    [0:SQ];
  logic                 clamp_d [0:END];
  logic [31:0]          roll_d [SQ+1:END];
  logic [31:0]          yaw_d  [SQ+1:END];

  logic [31:0] roll_z, yaw_z, pitch_z;
  logic signed [31:0] pitch_lim;

  logic signed [AB-1:0] roll_r, pitch_r, yaw_r;
  logic                 clamp_out_r, out_vld_r;

  function automatic logic [AB-1:0] rnd(logic [31:0] z);
    logic [32:0] s;
    s = {1'b0, z} + RND_HALF;
    return s[31 -: AB];
  endfunction

  assign {rn_q, rd_q, yn_q, yd_q, t_q, clamp_q} = q_dout;
  assign t_abs = t_q[31] ? 31'(-t_q) : t_q[30:0];

  // one global enable: freeze every stage while the result waits
  assign advance = !out_vld_r || out_ch.ready;
  assign q_pop   = advance && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= END; i++) begin
        vld_r[i] <= 1'b0;
      end
      out_vld_r <= 1'b0;
    end else if (advance) begin
      vld_r[0] <= q_pop;
      for (int i = 1; i <= END; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
      out_vld_r <= vld_r[END];
    end
  end

  // entry stage: latch request, form the radicand 2^60 - t^2
  always_ff @(posedge clk) begin
    if (advance) begin
      rn_r       <= rn_q;
      rd_r       <= rd_q;
      yn_r       <= yn_q;
      yd_r       <= yd_q;
      t_d[0]     <= t_q;
      clamp_d[0] <= clamp_q;
      n_r[0]     <= (62'd1 << 60) - 62'(t_abs) * 62'(t_abs);
      rem_r[0]   <= '0;
      root_r[0]  <= '0;
    end
  end

  // digit-by-digit square root, one root bit per stage
  always_ff @(posedge clk) begin
    logic [34:0] r2, trial;
    if (advance) begin
      for (int k = 1; k <= SQ; k++) begin
        r2    = {rem_r[k-1], n_r[k-1][61:60]};
        trial = {2'b00, root_r[k-1], 2'b01};
        if (r2 >= trial) begin
          rem_r[k]  <= 33'(r2 - trial);
          root_r[k] <= {root_r[k-1][29:0], 1'b1};
        end else begin
          rem_r[k]  <= 33'(r2);
          root_r[k] <= {root_r[k-1][29:0], 1'b0};
        end
        n_r[k] <= {n_r[k-1][59:0], 2'b00};
        t_d[k] <= t_d[k-1];
      end
    end
  end

  // delay roll, yaw angles and the clamp flag to meet the pitch CORDIC
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 1; k <= END; k++) begin
        clamp_d[k] <= clamp_d[k-1];
      end
      roll_d[SQ+1] <= roll_z;
      yaw_d[SQ+1]  <= yaw_z;
      for (int k = SQ + 2; k <= END; k++) begin
        roll_d[k] <= roll_d[k-1];
        yaw_d[k]  <= yaw_d[k-1];
      end
    end
  end

  qte_cordic #(.CW(CW)) u_roll (
    .clk (clk), .en (advance), .y_i (rn_r), .x_i (rd_r), .z_o (roll_z)
  );

  qte_cordic #(.CW(CW)) u_yaw (
    .clk (clk), .en (advance), .y_i (yn_r), .x_i (yd_r), .z_o (yaw_z)
  );

  qte_cordic #(.CW(CW)) u_pitch (
    .clk (clk),
    .en  (advance),
    .y_i (CW'(t_d[SQ])),
    .x_i (CW'({1'b0, root_r[SQ]})),
    .z_o (pitch_z)
  );

  // limit pitch to +-pi/2 before rounding
  always_comb begin
    pitch_lim = pitch_z;
    if (pitch_lim > LIM_POS) begin
      pitch_lim = LIM_POS;
    end else if (pitch_lim < LIM_NEG) begin
      pitch_lim = LIM_NEG;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      roll_r      <= rnd(roll_d[END]);
      yaw_r       <= rnd(yaw_d[END]);
      pitch_r     <= rnd(pitch_lim);
      clamp_out_r <= clamp_d[END];
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.roll          = roll_r;
  assign out_ch.pitch         = pitch_r;
  assign out_ch.yaw           = yaw_r;
  assign out_ch.pitch_clamped = clamp_out_r;

endmodule

[rtl/quaternion_to_euler_angles.sv]
// Quaternion to ZYX Euler angle converter, top level.
//
// Takes one quaternion (w, x, y, z) per request in signed fixed point with
// COMPONENT_BITS-1 fraction bits and returns roll, pitch and yaw as signed
// ANGLE_BITS binary angles (2^(ANGLE_BITS-1) is pi), plus pitch_clamped when
// the asin argument 2(wy - xz) fell outside +-1 and was clamped, in which
// case pitch is exactly +-pi/2. Non-unit quaternions are not normalized.
// Throughput: one request per cycle while out_ch.ready holds. Every stage
// is pipelined: the 30-iteration CORDICs run one iteration per stage and
// the 31-bit square root behind pitch yields one root bit per stage. The
// front end (products, atan2 operands, clamp) feeds a two-entry queue; the
// back end freezes as a whole while a result waits on out_ch.ready, and
// the front end keeps taking requests until the queue fills. Results leave
// in request order.
module quaternion_to_euler_angles import qte_pkg::*; #(
  parameter int COMPONENT_BITS = CB_DEFAULT,
  parameter int ANGLE_BITS     = AB_DEFAULT
) (
  input  logic      clk,
  input  logic      rst_n,
  qte_in_if.sink    in_ch,
  qte_out_if.source out_ch
);

  localparam int CW = cordic_width(COMPONENT_BITS);
  localparam int QW = 4 * CW + 33;

  logic          push, q_full, q_pop, q_empty;
  logic [QW-1:0] push_data, q_dout;

  // accept and precompute
  qte_front #(
    .COMPONENT_BITS (COMPONENT_BITS),
    .CW             (CW),
    .QW             (QW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  // decouple front and back stalls
  qte_queue #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (push_data),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  // square root, CORDICs and result register
  qte_back #(
    .ANGLE_BITS (ANGLE_BITS),
    .CW         (CW),
    .QW         (QW)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_dout  (q_dout),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

[rtl/qte_checker.sv]
// Port-level checker for the quaternion to Euler converter, bound to the top level.
`include "quaternion_to_euler_angles_defines.svh"

module qte_checker import qte_pkg::*; #(
  parameter int ANGLE_BITS = AB_DEFAULT
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [ANGLE_BITS-1:0] roll,
  input logic signed [ANGLE_BITS-1:0] pitch,
  input logic signed [ANGLE_BITS-1:0] yaw,
  input logic                         pitch_clamped
);

  localparam logic signed [ANGLE_BITS-1:0] QP = ANGLE_BITS'(1) <<< (ANGLE_BITS - 2);

  `QTE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `QTE_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(roll) && $stable(pitch) && $stable(yaw) && $stable(pitch_clamped))
  `QTE_ASSERT_IMPL(a_pitch_range, clk, rst_n, out_valid, pitch <= QP && pitch >= -QP)
  `QTE_ASSERT_IMPL(a_clamp_axis, clk, rst_n, out_valid && pitch_clamped, pitch == QP || pitch == -QP)

endmodule

bind quaternion_to_euler_angles qte_checker #(
  .ANGLE_BITS (ANGLE_BITS)
) u_qte_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .roll          (out_ch.roll),
  .pitch         (out_ch.pitch),
  .yaw           (out_ch.yaw),
  .pitch_clamped (out_ch.pitch_clamped)
);
